@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants of the UTF-8 stream decoder with escape skipping.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   // Default width of the byte offset counter
   localparam int OFFSET_BITS_DEFAULT = 32;
   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   // Code point and output offset widths
   localparam int CP_BITS   = 21;
   localparam int OUT_OFF_BITS = 32;

   // Special bytes
   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] BYTE_ESC     = 8'h1B;
   localparam logic [7:0] BYTE_BRACKET = 8'h5B;

   // Lead byte ranges
   localparam logic [7:0] LEAD_LOW    = 8'hC2;
   localparam logic [7:0] LEAD_HIGH   = 8'hF4;
   localparam logic [7:0] LEAD3_FIRST = 8'hE0;
   localparam logic [7:0] LEAD4_FIRST = 8'hF0;

   // Leads with a restricted first continuation
   localparam logic [7:0] LEAD_SURR   = 8'hED;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] CONT_SURR_MAX = 8'h9F;
   localparam logic [7:0] CONT_E0_MIN   = 8'hA0;
   localparam logic [7:0] CONT_F0_MIN   = 8'h90;
   localparam logic [7:0] CONT_F4_MAX   = 8'h8F;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_VALID   = 2'd0,
      KIND_INVALID = 2'd1,
      KIND_ESCAPE  = 2'd2
   } kind_type;

   // Work handed from front to back for one accepted byte:
   // a head group of head_count results at consecutive offsets from the
   // base, then an optional tail result at the byte's own offset.
   typedef struct packed {
      logic [1:0]         head_count;
      kind_type           head_kind;
      logic [CP_BITS-1:0] head_cp;
      logic               tail_en;
      kind_type           tail_kind;
      logic [7:0]         tail_byte;
   } desc_type;

endpackage

@@ rtl/u8dec_if.sv @@
// ----------------------------------------------------------------------------
// u8dec_req_if / u8dec_rsp_if
// Valid/ready channels carrying raw text bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface u8dec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8dec_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [1:0]  kind;
   logic [31:0] start_offset;
   logic        last_of_run;

   modport source (output valid, output code_point, output kind, output start_offset,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input kind, input start_offset,
                   input last_of_run, output ready);
endinterface

@@ rtl/u8dec_front.sv @@
// ----------------------------------------------------------------------------
// u8dec_front
// Takes one byte per cycle while the queue has room, tracks the decoder state
// and writes a compact description of the byte's results into the queue.
// ----------------------------------------------------------------------------
module u8dec_front import u8dec_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_text,
   input  logic                   q_full,
   output logic                   q_push,
   output desc_type               q_desc,
   output logic [OFFSET_BITS-1:0] q_base,
   output logic [OFFSET_BITS-1:0] q_pos
);

   // Decoder state
   logic [OFFSET_BITS-1:0] pos_ff,   pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [7:0]             lead_ff,  lead_in;
   logic [1:0]             need_ff,  need_in;
   logic [1:0]             held_ff,  held_in;
   logic [CP_BITS-1:0]     value_ff, value_in;
   logic                   esc_ff,   esc_in;
   logic                   inesc_ff, inesc_in;

   // Byte classes
   logic is_nul, is_esc, is_ascii, is_letter, good_lead, cont_ok, fits;
   logic use_lead, accept;
   logic [CP_BITS-1:0] value_ext;
   desc_type desc;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // Classification of the incoming byte
   always_comb begin
      is_nul    = (data_byte == BYTE_NUL);
      is_esc    = (data_byte == BYTE_ESC);
      is_ascii  = !data_byte[7];
      is_letter = data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      good_lead = data_byte inside {[LEAD_LOW:LEAD_HIGH]};
      cont_ok   = (data_byte[7:6] == 2'b10);
      fits      = cont_ok;
      if (held_ff == 2'd0) begin
         if ((lead_ff == LEAD_SURR && data_byte > CONT_SURR_MAX) ||
             (lead_ff == LEAD_E0   && data_byte < CONT_E0_MIN)   ||
             (lead_ff == LEAD_F0   && data_byte < CONT_F0_MIN)   ||
             (lead_ff == LEAD_F4   && data_byte > CONT_F4_MAX)) begin
            fits = 1'b0;
         end
      end
      value_ext = {value_ff[CP_BITS-7:0], data_byte[5:0]};
   end

   // Next state and work description
   always_comb begin
      pos_in   = pos_ff;
      start_in = start_ff;
      lead_in  = lead_ff;
      need_in  = need_ff;
      held_in  = held_ff;
      value_in = value_ff;
      esc_in   = esc_ff;
      inesc_in = inesc_ff;
      use_lead = 1'b0;

      desc            = '0;
      desc.head_kind  = KIND_INVALID;
      desc.tail_kind  = KIND_INVALID;
      desc.tail_byte  = data_byte;

      if (inesc_ff) begin
         // inside a skipped escape sequence
         if (is_nul || is_letter || end_of_text) begin
            desc.head_count = 2'd1;
            desc.head_kind  = KIND_ESCAPE;
            inesc_in        = 1'b0;
         end
      end else if (esc_ff) begin
         esc_in = 1'b0;
         if (data_byte == BYTE_BRACKET) begin
            inesc_in = 1'b1;
            if (end_of_text) begin
               desc.head_count = 2'd1;
               desc.head_kind  = KIND_ESCAPE;
            end
         end else begin
            // lone ESC is an ordinary code point
            desc.head_count = 2'd1;
            desc.head_kind  = KIND_VALID;
            desc.head_cp    = CP_BITS'(BYTE_ESC);
            use_lead        = 1'b1;
         end
      end else if (need_ff != 2'd0) begin
         if (fits) begin
            value_in = value_ext;
            need_in  = need_ff - 2'd1;
            if (need_ff == 2'd1) begin
               desc.head_count = 2'd1;
               desc.head_kind  = KIND_VALID;
               desc.head_cp    = value_ext;
               lead_in  = '0;
               held_in  = '0;
               value_in = '0;
            end else begin
               held_in = held_ff + 2'd1;
               if (end_of_text) begin
                  // lead, every continuation held so far and this byte
                  desc.head_count = held_ff + 2'd2;
                  desc.head_kind  = KIND_INVALID;
               end
            end
         end else begin
            // broken sequence, breaking byte starts afresh
            desc.head_count = held_ff + 2'd1;
            desc.head_kind  = KIND_INVALID;
            lead_in  = '0;
            need_in  = '0;
            held_in  = '0;
            value_in = '0;
            use_lead = 1'b1;
         end
      end else begin
         use_lead = 1'b1;
      end

      // Byte taken as a lead
      if (use_lead) begin
         desc.tail_kind = (is_ascii && !is_nul) ? KIND_VALID : KIND_INVALID;
         desc.tail_en   = is_nul || (is_ascii && !is_esc) || (!is_ascii && !good_lead) ||
                          (end_of_text && (is_esc || good_lead));
         if (is_esc) begin
            esc_in   = 1'b1;
            start_in = pos_ff;
         end else if (!is_ascii && good_lead) begin
            lead_in  = data_byte;
            start_in = pos_ff;
            held_in  = '0;
            if (data_byte < LEAD3_FIRST) begin
               need_in  = 2'd1;
               value_in = CP_BITS'(data_byte[4:0]);
            end else if (data_byte < LEAD4_FIRST) begin
               need_in  = 2'd2;
               value_in = CP_BITS'(data_byte[3:0]);
            end else begin
               need_in  = 2'd3;
               value_in = CP_BITS'(data_byte[2:0]);
            end
         end
      end

      // End of text flushes everything
      if (end_of_text) begin
         pos_in   = '0;
         start_in = '0;
         lead_in  = '0;
         need_in  = '0;
         held_in  = '0;
         value_in = '0;
         esc_in   = 1'b0;
         inesc_in = 1'b0;
      end else begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end
   end

   assign q_push = accept && ((desc.head_count != 2'd0) || desc.tail_en);
   assign q_desc = desc;
   assign q_base = start_ff;
   assign q_pos  = pos_ff;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         lead_ff  <= '0;
         need_ff  <= '0;
         held_ff  <= '0;
         value_ff <= '0;
         esc_ff   <= 1'b0;
         inesc_ff <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         lead_ff  <= lead_in;
         need_ff  <= need_in;
         held_ff  <= held_in;
         value_ff <= value_in;
         esc_ff   <= esc_in;
         inesc_ff <= inesc_in;
      end
   end

endmodule

@@ rtl/u8dec_queue.sv @@
// ----------------------------------------------------------------------------
// u8dec_queue
// Small first-in first-out queue of work descriptions between front and back.
// ----------------------------------------------------------------------------
module u8dec_queue import u8dec_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/u8dec_back.sv @@
// ----------------------------------------------------------------------------
// u8dec_back
// Expands each work description into its results, one per cycle while the
// queue is not empty and the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module u8dec_back import u8dec_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  desc_type                q_desc,
   input  logic [OFFSET_BITS-1:0]  q_base,
   input  logic [OFFSET_BITS-1:0]  q_pos,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CP_BITS-1:0]      code_point,
   output kind_type                kind,
   output logic [OUT_OFF_BITS-1:0] start_offset,
   output logic                    last_of_run
);

   logic [1:0]              idx_ff, idx_in;
   logic                    valid_ff, valid_in;
   logic [CP_BITS-1:0]      cp_ff, cp_in;
   kind_type                kind_ff, kind_in;
   logic [OUT_OFF_BITS-1:0] off_ff, off_in;
   logic                    last_ff, last_in;

   logic [2:0]              total;
   logic                    load, fire;
   logic [OFFSET_BITS-1:0]  off_full;

   assign load = !valid_ff || rsp_ready;
   assign fire = load && !q_empty;

   // Pick the result at the current index of the head description
   always_comb begin
      total   = {1'b0, q_desc.head_count} + {2'b00, q_desc.tail_en};
      last_in = (({1'b0, idx_ff} + 3'd1) == total);
      if ({1'b0, idx_ff} < {1'b0, q_desc.head_count}) begin
         kind_in  = q_desc.head_kind;
         cp_in    = (q_desc.head_kind == KIND_VALID) ? q_desc.head_cp : '0;
         off_full = q_base + OFFSET_BITS'(idx_ff);
      end else begin
         kind_in  = q_desc.tail_kind;
         cp_in    = (q_desc.tail_kind == KIND_VALID) ? CP_BITS'(q_desc.tail_byte) : '0;
         off_full = q_pos;
      end
      off_in = OUT_OFF_BITS'(off_full);
   end

   // Index and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
         idx_in   = last_in ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   assign q_pop = fire && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (fire) begin
         cp_ff   <= cp_in;
         kind_ff <= kind_in;
         off_ff  <= off_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign code_point   = cp_ff;
   assign kind         = kind_ff;
   assign start_offset = off_ff;
   assign last_of_run  = last_ff;

endmodule

@@ rtl/utf8_stream_decoder_with_csi_skip_top.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_with_csi_skip_top
// Strict UTF-8 stream decoder that skips ESC '[' escape sequences.
//
//   channel  dir  handshake        payload
//   req_ch   in   valid / ready    data_byte[7:0], end_of_text
//   rsp_ch   out  valid / ready    code_point[20:0], kind[1:0],
//                                  start_offset[31:0], last_of_run
//
// One byte is taken per cycle while the queue has room; a byte gives 0 to 4
// results, one per cycle from the back end while rsp ready does not stall it.
// The first result of a byte passes through the queue and then the back end's
// output register. A four-entry queue absorbs bursts between front and back;
// req ready drops only when it is full. Reset is synchronous.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_with_csi_skip_top import u8dec_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   u8dec_req_if.sink   req_ch,
   u8dec_rsp_if.source rsp_ch
);

   localparam int Q_WIDTH = $bits(desc_type) + 2 * OFFSET_BITS;

   desc_type               f_desc, b_desc;
   logic [OFFSET_BITS-1:0] f_base, f_pos, b_base, b_pos;
   logic                   q_push, q_pop, q_full, q_empty;
   logic [Q_WIDTH-1:0]     q_wdata, q_rdata;
   kind_type               rsp_kind;

   // Front: classify bytes, keep decoder state
   u8dec_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .data_byte   (req_ch.data_byte),
      .end_of_text (req_ch.end_of_text),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (f_desc),
      .q_base      (f_base),
      .q_pos       (f_pos)
   );

   assign q_wdata = {f_desc, f_base, f_pos};

   // Work queue
   u8dec_queue #(.WIDTH(Q_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign {b_desc, b_base, b_pos} = q_rdata;

   // Back: expand into results
   u8dec_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_desc       (b_desc),
      .q_base       (b_base),
      .q_pos        (b_pos),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .code_point   (rsp_ch.code_point),
      .kind         (rsp_kind),
      .start_offset (rsp_ch.start_offset),
      .last_of_run  (rsp_ch.last_of_run)
   );

   assign rsp_ch.kind = rsp_kind;

endmodule

@@ rtl/u8dec_checker.sv @@
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8dec_checker import u8dec_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [CP_BITS-1:0]      code_point,
   input logic [1:0]              kind,
   input logic [OUT_OFF_BITS-1:0] start_offset,
   input logic                    last_of_run
);

   // no result straight after reset
   `ASSERT_CLK_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // only valid items carry a code point
   `ASSERT_CLK(a_cp_zero, clock, reset, (rsp_valid && kind != KIND_VALID) |-> (code_point == '0), "non-zero code point on a non-valid item")

   // decoded values are scalar values: no surrogates, nothing past 10FFFF
   `ASSERT_CLK(a_scalar, clock, reset, (rsp_valid && kind == KIND_VALID) |-> ((code_point <= 21'h10FFFF) && !((code_point >= 21'h00D800) && (code_point <= 21'h00DFFF))), "decoded value is not a scalar value")

   // a stalled item holds
   `ASSERT_CLK(a_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(code_point) && $stable(kind) && $stable(start_offset) && $stable(last_of_run)), "stalled item changed")

endmodule

bind utf8_stream_decoder_with_csi_skip_top u8dec_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .code_point   (rsp_ch.code_point),
   .kind         (rsp_ch.kind),
   .start_offset (rsp_ch.start_offset),
   .last_of_run  (rsp_ch.last_of_run)
);
